// File: sv/lpm_route_table_unit_defines.svh
// Assertion macros used by the route table top module.
// Depends on nothing; every user must have clk and rst_n in scope.
`ifndef LPM_ROUTE_TABLE_UNIT_DEFINES_SVH
`define LPM_ROUTE_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LRT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define LRT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/lrt_pkg.sv
// Package for the route table: sizes, operation codes and the token
// that travels along the row of table cells. Depends on nothing.
package lrt_pkg;

    localparam int ENTRIES    = 8;
    localparam int IFACE_BITS = 4;

    // Operation codes of an input item.
    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2
    } op_t;

    // One operation in flight, with the running add and lookup results.
    typedef struct packed {
        logic [1:0]            op;
        logic [31:0]           addr;
        logic [31:0]           mask;
        logic [31:0]           gateway;
        logic [IFACE_BITS-1:0] iface;
        logic                  done;
        logic                  found;
        logic [31:0]           best_dest;
        logic [31:0]           best_mask;
        logic [31:0]           best_gateway;
        logic [IFACE_BITS-1:0] best_iface;
    } token_t;

endpackage

// File: sv/lrt_in_if.sv
// Request channel of the route table: valid/ready plus one operation item.
// Depends on nothing.
interface lrt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [31:0] addr;
    logic [31:0] mask;
    logic [31:0] gateway;
    logic [3:0]  iface;

    modport source (output valid, op, addr, mask, gateway, iface, input ready);
    modport sink   (input valid, op, addr, mask, gateway, iface, output ready);
endinterface

// File: sv/lrt_out_if.sv
// Result channel of the route table: valid/ready plus one result item.
// Depends on nothing.
interface lrt_out_if;
    logic        valid;
    logic        ready;
    logic        success;
    logic [3:0]  out_iface;
    logic [31:0] out_gateway;
    logic [31:0] out_dest;
    logic [31:0] out_mask;

    modport source (output valid, success, out_iface, out_gateway, out_dest, out_mask,
                    input ready);
    modport sink   (input valid, success, out_iface, out_gateway, out_dest, out_mask,
                    output ready);
endinterface

// File: sv/lrt_cell.sv
// One route slot of the table and one stage of the token chain.
// Depends on lrt_pkg.
module lrt_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            tok_valid_in,
    input  lrt_pkg::token_t tok_in,
    output logic            tok_valid_out,
    output lrt_pkg::token_t tok_out
);
    import lrt_pkg::*;

    logic [31:0]           dest_reg, dest_next;
    logic [31:0]           mask_reg, mask_next;
    logic [31:0]           gateway_reg, gateway_next;
    logic [IFACE_BITS-1:0] iface_reg, iface_next;
    logic                  tok_valid_reg;
    token_t                tok_reg, tok_next;
    logic                  match;

    // Apply the passing operation to this slot and update the running result.
    always_comb
    begin
        dest_next    = dest_reg;
        mask_next    = mask_reg;
        gateway_next = gateway_reg;
        iface_next   = iface_reg;
        tok_next     = tok_in;
        match        = ((tok_in.addr ^ dest_reg) & mask_reg) == 32'd0;
        if (tok_valid_in)
        begin
            unique case (tok_in.op)
                OP_ADD:
                begin
                    // First free slot along the row takes the route.
                    if (!tok_in.done && iface_reg == '0)
                    begin
                        dest_next     = tok_in.addr;
                        mask_next     = tok_in.mask;
                        gateway_next  = tok_in.gateway;
                        iface_next    = tok_in.iface;
                        tok_next.done = 1'b1;
                    end
                end
                OP_REMOVE:
                begin
                    if (iface_reg == tok_in.iface)
                    begin
                        dest_next    = 32'd0;
                        mask_next    = 32'd0;
                        gateway_next = 32'd0;
                        iface_next   = '0;
                    end
                end
                OP_LOOKUP:
                begin
                    // Strictly longer mask replaces, so the earliest slot wins ties.
                    if (match && (!tok_in.found || mask_reg > tok_in.best_mask))
                    begin
                        tok_next.found        = 1'b1;
                        tok_next.best_dest    = dest_reg;
                        tok_next.best_mask    = mask_reg;
                        tok_next.best_gateway = gateway_reg;
                        tok_next.best_iface   = iface_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Slot contents are table state and clear at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_reg      <= 32'd0;
            mask_reg      <= 32'd0;
            gateway_reg   <= 32'd0;
            iface_reg     <= '0;
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            dest_reg      <= dest_next;
            mask_reg      <= mask_next;
            gateway_reg   <= gateway_next;
            iface_reg     <= iface_next;
            tok_valid_reg <= tok_valid_in;
        end
    end

    // Token payload moves on to the neighbor.
    always_ff @(posedge clk)
    begin
        if (tok_valid_in)
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_valid_out = tok_valid_reg;
    assign tok_out       = tok_reg;
endmodule

// File: sv/lpm_route_table_unit.sv
// Longest-prefix-match route table of ENTRIES slots, cleared at reset. Each
// item (add, remove or lookup) walks a row of ENTRIES cells, one slot per
// cycle, and gives one result item. An item passes through the cell row,
// the tail stage and the output register, and a new item is accepted only
// once the previous one's result is loaded into the output register; one
// item is in the table at a time. A result held by a stalled output does not
// block the next item from entering the row, but that item's result waits in
// the tail stage until the output is free.
// Depends on lrt_pkg, lrt_in_if, lrt_out_if, lrt_cell and the defines header.
module lpm_route_table_unit (
    input logic      clk,
    input logic      rst_n,
    lrt_in_if.sink   req,
    lrt_out_if.source rsp
);
    import lrt_pkg::*;
    `include "lpm_route_table_unit_defines.svh"

    logic [ENTRIES:0] tok_valid;
    token_t           tok [ENTRIES+1];
    logic             busy_reg;
    logic             accept;
    logic             tail_valid_reg;
    token_t           tail_tok_reg;
    logic             load_out;
    logic             out_valid_reg;
    logic             success_reg, success_next;
    logic [3:0]       iface_reg, iface_next;
    logic [31:0]      gateway_reg, gateway_next;
    logic [31:0]      dest_reg, dest_next;
    logic [31:0]      mask_reg, mask_next;

    // Build the token for a newly accepted item.
    assign req.ready    = !busy_reg;
    assign accept       = req.valid && !busy_reg;
    assign tok_valid[0] = accept;
    always_comb
    begin
        tok[0]              = '0;
        tok[0].op           = req.op;
        tok[0].addr         = req.addr;
        tok[0].mask         = req.mask;
        tok[0].gateway      = req.gateway;
        tok[0].iface        = req.iface[IFACE_BITS-1:0];
    end

    // Row of table cells.
    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        lrt_cell u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .tok_valid_in  (tok_valid[i]),
            .tok_in        (tok[i]),
            .tok_valid_out (tok_valid[i+1]),
            .tok_out       (tok[i+1])
        );
    end

    assign load_out = tail_valid_reg && (!out_valid_reg || rsp.ready);

    // Turn the finished token into a result item.
    always_comb
    begin
        success_next = 1'b0;
        iface_next   = 4'd0;
        gateway_next = 32'd0;
        dest_next    = 32'd0;
        mask_next    = 32'd0;
        unique case (tail_tok_reg.op)
            OP_ADD:    success_next = tail_tok_reg.done;
            OP_REMOVE: success_next = 1'b1;
            OP_LOOKUP:
            begin
                if (tail_tok_reg.found && tail_tok_reg.best_iface != '0)
                begin
                    success_next = 1'b1;
                    iface_next   = 4'(tail_tok_reg.best_iface);
                    gateway_next = tail_tok_reg.best_gateway;
                    dest_next    = tail_tok_reg.best_dest;
                    mask_next    = tail_tok_reg.best_mask;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control: busy flag, tail holding stage and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            tail_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (load_out)
            begin
                busy_reg <= 1'b0;
            end
            if (tok_valid[ENTRIES])
            begin
                tail_valid_reg <= 1'b1;
            end
            else if (load_out)
            begin
                tail_valid_reg <= 1'b0;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload of the tail stage and the output register.
    always_ff @(posedge clk)
    begin
        if (tok_valid[ENTRIES])
        begin
            tail_tok_reg <= tok[ENTRIES];
        end
        if (load_out)
        begin
            success_reg <= success_next;
            iface_reg   <= iface_next;
            gateway_reg <= gateway_next;
            dest_reg    <= dest_next;
            mask_reg    <= mask_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.success     = success_reg;
    assign rsp.out_iface   = iface_reg;
    assign rsp.out_gateway = gateway_reg;
    assign rsp.out_dest    = dest_reg;
    assign rsp.out_mask    = mask_reg;

    // At most one item is in the cell row or the tail stage.
    `LRT_ASSERT_IMPL(a_one_token, 1'b1, $onehot0({tok_valid[ENTRIES:1], tail_valid_reg}), "more than one item in flight")
    // An accepted item keeps the block busy until its result is loaded.
    `LRT_ASSERT_NEXT(a_accept_busy, accept, busy_reg, "busy not set after accept")
    // A token leaving the row or held in the tail always belongs to a busy block.
    `LRT_ASSERT_IMPL(a_token_busy, tok_valid[ENTRIES] || tail_valid_reg, busy_reg, "token while idle")
    // Loading a result makes it visible in the next cycle.
    `LRT_ASSERT_NEXT(a_load_valid, load_out, out_valid_reg, "loaded result not valid")
endmodule
